### sv/efb_pkg.sv
// Shared types, constants and the CRC byte update for the Ethernet frame builder.
package efb_pkg;

   localparam int MAX_PAYLOAD = 1500;
   localparam int MIN_PAYLOAD = 46;
   localparam int CNT_W       = 11;
   localparam int PAD_W       = 6;
   localparam int HDR_LEN     = 14;
   localparam int IDX_W       = 4;
   localparam int MAC_W       = 48;
   localparam int TYPE_W      = 16;
   localparam int CSR_W       = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = 2;
   localparam int OUT_DEPTH   = 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [TYPE_W-1:0] ETHER_TYPE_RST = 16'h0800;

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_MAC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_MAC    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ETHER_TYPE = 2'd2;

   typedef struct packed {
      logic [MAC_W-1:0]  dest_mac;
      logic [MAC_W-1:0]  src_mac;
      logic [TYPE_W-1:0] ether_type;
   } hdr_cfg_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             hdr;
      logic             close;
      logic [PAD_W-1:0] pad;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fend;
      logic       last;
   } out_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      end
      return r;
   endfunction

endpackage

### sv/efb_front.sv
// Front end: accepts payload items, tracks frame fill and queues framing commands.
module efb_front import efb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  logic [7:0] payload_byte,
   input  logic    data_end,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type                q_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CMD_PTR_W:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]       count_ff, count_in, cnt_new;
   logic                   in_frame_ff, in_frame_in;
   logic                   accept, do_pop, close;
   cmd_type                new_cmd;

   assign full      = (cnt_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      cnt_new       = count_ff + CNT_W'(1);
      close         = data_end || (cnt_new >= CNT_W'(MAX_PAYLOAD));
      new_cmd.data  = payload_byte;
      new_cmd.hdr   = !in_frame_ff;
      new_cmd.close = close;
      new_cmd.pad   = (close && (cnt_new < CNT_W'(MIN_PAYLOAD)))
                      ? PAD_W'(CNT_W'(MIN_PAYLOAD) - cnt_new) : '0;
      count_in      = count_ff;
      in_frame_in   = in_frame_ff;
      if (accept) begin
         count_in    = close ? '0 : cnt_new;
         in_frame_in = !close;
      end
      cnt_in = cnt_ff + (CMD_PTR_W+1)'(accept) - (CMD_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
         count_ff    <= '0;
         in_frame_ff <= 1'b0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
         cnt_ff      <= cnt_in;
         count_ff    <= count_in;
         in_frame_ff <= in_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### sv/efb_back.sv
// Back end: byte sequencer for header, payload, padding and FCS, with CRC and result queue.
module efb_back import efb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  hdr_cfg_type cfg,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  frame_byte,
   output logic        frame_end,
   output logic        run_last
);

   typedef enum logic [1:0] {PH_HDR, PH_DATA, PH_PAD, PH_FCS} phase_type;

   phase_type          phase_ff, phase_in;
   logic               busy_ff;
   cmd_type            cur_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in, hdr_sel;
   logic [PAD_W-1:0]   pad_ff, pad_in;
   logic [31:0]        crc_ff, fcs;
   logic [8*HDR_LEN-1:0] hdr_word;
   logic               step, fin, crc_en, ld;
   out_type            emit;

   out_type            oq_ff [OUT_DEPTH];
   logic               owr_ff, ord_ff;
   logic [1:0]         ocnt_ff;
   logic               opop;

   assign hdr_word = {cfg.dest_mac, cfg.src_mac, cfg.ether_type};
   assign hdr_sel  = IDX_W'(HDR_LEN - 1) - idx_ff;
   assign fcs      = ~crc_ff;
   assign step     = busy_ff && (ocnt_ff != 2'(OUT_DEPTH));

   always_comb begin
      emit     = '0;
      crc_en   = 1'b1;
      fin      = 1'b0;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      case (phase_ff)
         PH_HDR: begin
            emit.data = hdr_word[{hdr_sel, 3'b000} +: 8];
            if (idx_ff == IDX_W'(HDR_LEN - 1)) begin
               phase_in = PH_DATA;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         PH_DATA: begin
            emit.data = cur_ff.data;
            if (!cur_ff.close) begin
               fin = 1'b1;
            end else if (cur_ff.pad != '0) begin
               phase_in = PH_PAD;
               pad_in   = cur_ff.pad;
            end else begin
               phase_in = PH_FCS;
               idx_in   = '0;
            end
         end
         PH_PAD: begin
            emit.data = 8'd0;
            pad_in    = pad_ff - PAD_W'(1);
            if (pad_ff == PAD_W'(1)) begin
               phase_in = PH_FCS;
               idx_in   = '0;
            end
         end
         PH_FCS: begin
            crc_en    = 1'b0;
            emit.data = fcs[{idx_ff[1:0], 3'b000} +: 8];
            idx_in    = idx_ff + IDX_W'(1);
            if (idx_ff[1:0] == 2'd3) begin
               emit.fend = 1'b1;
               fin       = 1'b1;
            end
         end
         default: begin
            crc_en = 1'b0;
         end
      endcase
      emit.last = fin;
      ld        = cmd_valid && (!busy_ff || (step && fin));
   end

   assign cmd_pop = ld;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_HDR;
         idx_ff   <= '0;
         pad_ff   <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         if (step) begin
            if (emit.fend) begin
               crc_ff <= CRC_INIT;
            end else if (crc_en) begin
               crc_ff <= crc_byte(crc_ff, emit.data);
            end
         end
         if (ld) begin
            busy_ff  <= 1'b1;
            phase_ff <= cmd.hdr ? PH_HDR : PH_DATA;
            idx_ff   <= '0;
         end else if (step && fin) begin
            busy_ff <= 1'b0;
         end else if (step) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            pad_ff   <= pad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         cur_ff <= cmd;
      end
   end

   // result queue
   assign empty      = (ocnt_ff == 2'd0);
   assign opop       = pop && !empty;
   assign frame_byte = oq_ff[ord_ff].data;
   assign frame_end  = oq_ff[ord_ff].fend;
   assign run_last   = oq_ff[ord_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= '0;
      end else begin
         if (step) begin
            owr_ff <= !owr_ff;
         end
         if (opop) begin
            ord_ff <= !ord_ff;
         end
         ocnt_ff <= ocnt_ff + 2'(step) - 2'(opop);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         oq_ff[owr_ff] <= emit;
      end
   end

endmodule

### sv/ethernet_frame_builder.sv
// Ethernet II frame builder top level: CSR registers, front end and back end.
// An accepted item is queued, loaded into the back end and emitted into the result queue.
// Throughput: one frame byte per cycle while the result queue has room. A payload item
// gives one byte; a frame start adds 14 header bytes, a close 0 to 45 pad and 4 FCS bytes.
// Input stalls only when the four-entry command queue between front and back is full.
// Synchronous reset empties both queues, closes any frame and restores the CSR defaults.
module ethernet_frame_builder import efb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [7:0]           req_payload_byte,
   input  logic                 req_data_end,
   output logic                 empty,
   input  logic                 pop,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_frame_end,
   output logic                 rsp_run_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   hdr_cfg_type cfg_ff;
   cmd_type     cmd;
   logic        cmd_valid, cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_mac   <= '0;
         cfg_ff.src_mac    <= '0;
         cfg_ff.ether_type <= ETHER_TYPE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEST_MAC:   cfg_ff.dest_mac   <= csr_wdata[MAC_W-1:0];
            CSR_SRC_MAC:    cfg_ff.src_mac    <= csr_wdata[MAC_W-1:0];
            CSR_ETHER_TYPE: cfg_ff.ether_type <= csr_wdata[TYPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   efb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .payload_byte (req_payload_byte),
      .data_end     (req_data_end),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   efb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .empty      (empty),
      .pop        (pop),
      .frame_byte (rsp_frame_byte),
      .frame_end  (rsp_frame_end),
      .run_last   (rsp_run_last)
   );

endmodule

### sim/tb_ethernet_frame_builder.sv
// Self-checking testbench for the Ethernet II frame builder: header, padding and CRC-32 FCS.
module tb_ethernet_frame_builder;
   import efb_pkg::*;

   localparam int LIMIT       = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam int RAND_ITEMS  = 81;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [7:0] pb;
      logic       de;
      int         n_exp;
      logic [7:0] first_exp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [7:0]           req_payload_byte = 8'd0;
   logic                 req_data_end = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [7:0]           rsp_frame_byte;
   logic                 rsp_frame_end;
   logic                 rsp_run_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DEST_MAC;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // predictor state
   hdr_cfg_type cfg;
   logic [31:0] fcs_acc;
   int          pay_cnt;
   logic        open_frame;
   out_type     frame_q[$];
   int          run_n;
   logic [7:0]  run_first;

   int errors = 0;
   int items_sent = 0;
   int bytes_checked = 0;
   int frames_seen = 0;
   int cycles = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_req = 1'b0;
   int hold_left = 0;

   stim_row_type dir_tab [0:14];

   ethernet_frame_builder dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] fcs_update(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic fend, input logic in_fcs);
      out_type r;
      r.data = b;
      r.fend = fend;
      r.last = 1'b0;
      if (in_fcs) fcs_acc = fcs_update(fcs_acc, b);
      if (run_n == 0) run_first = b;
      run_n++;
      frame_q.push_back(r);
   endfunction

   function automatic void frame_predict(input logic [7:0] pb, input logic de);
      logic [31:0] fcs;
      out_type     tail;
      if (!open_frame) begin
         fcs_acc = CRC_INIT;
         pay_cnt = 0;
         for (int k = 5; k >= 0; k--) emit_byte(cfg.dest_mac[8*k +: 8], 1'b0, 1'b1);
         for (int k = 5; k >= 0; k--) emit_byte(cfg.src_mac[8*k +: 8], 1'b0, 1'b1);
         emit_byte(cfg.ether_type[15:8], 1'b0, 1'b1);
         emit_byte(cfg.ether_type[7:0], 1'b0, 1'b1);
         open_frame = 1'b1;
      end
      emit_byte(pb, 1'b0, 1'b1);
      pay_cnt++;
      if (de || pay_cnt >= MAX_PAYLOAD) begin
         while (pay_cnt < MIN_PAYLOAD) begin
            emit_byte(8'd0, 1'b0, 1'b1);
            pay_cnt++;
         end
         fcs = ~fcs_acc;
         emit_byte(fcs[7:0], 1'b0, 1'b0);
         emit_byte(fcs[15:8], 1'b0, 1'b0);
         emit_byte(fcs[23:16], 1'b0, 1'b0);
         emit_byte(fcs[31:24], 1'b1, 1'b0);
         fcs_acc    = CRC_INIT;
         pay_cnt    = 0;
         open_frame = 1'b0;
      end
      tail = frame_q.pop_back();
      tail.last = 1'b1;
      frame_q.push_back(tail);
   endfunction

   function automatic logic [CSR_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DEST_MAC:   cfg.dest_mac   = val[MAC_W-1:0];
         CSR_SRC_MAC:    cfg.src_mac    = val[MAC_W-1:0];
         CSR_ETHER_TYPE: cfg.ether_type = val[TYPE_W-1:0];
         default: ;
      endcase
   endtask

   // spare index goes last so a bad decode would corrupt a live register
   task automatic cfg_load(input logic [CSR_W-1:0] dmac, input logic [CSR_W-1:0] smac,
                           input logic [CSR_W-1:0] etype);
      csr_write(CSR_DEST_MAC, dmac);
      csr_write(CSR_SRC_MAC, smac);
      csr_write(CSR_ETHER_TYPE, etype);
      csr_write(CSR_SPARE, rand48());
      csr_we <= 1'b0;
   endtask

   task automatic offer(input logic [7:0] pb, input logic de);
      if ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      push             <= 1'b1;
      req_payload_byte <= pb;
      req_data_end     <= de;
      do @(posedge clock); while (full);
      items_sent++;
      run_n = 0;
      frame_predict(pb, de);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // mostly well-formed frames around the padding boundary; some with stray end marks
   task automatic random_frames(input int n_items);
      int left;
      int len;
      int sel;
      bit noisy;
      logic de;
      left = n_items;
      while (left > 0) begin
         noisy = ($urandom_range(99) < 15);
         sel   = $urandom_range(9);
         if (sel <= 5)      len = $urandom_range(1, 45);
         else if (sel == 6) len = $urandom_range(45, 47);
         else               len = $urandom_range(48, 100);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            de = noisy ? ($urandom_range(9) == 0) : (i == len - 1);
            offer(8'($urandom_range(255)), de);
         end
         left -= len;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         pop       <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left <= HOLD_CYCLES;
         pop       <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      out_type want;
      if (!reset && pop && !empty) begin
         if (frame_q.size() == 0) begin
            $display("%0t: unexpected item byte=%02h end=%b last=%b", $time,
                     rsp_frame_byte, rsp_frame_end, rsp_run_last);
            errors++;
         end else begin
            want = frame_q.pop_front();
            if (rsp_frame_byte !== want.data) begin
               $display("%0t: frame_byte expected %02h actual %02h", $time,
                        want.data, rsp_frame_byte);
               errors++;
            end
            if (rsp_frame_end !== want.fend) begin
               $display("%0t: frame_end expected %b actual %b", $time, want.fend, rsp_frame_end);
               errors++;
            end
            if (rsp_run_last !== want.last) begin
               $display("%0t: run_last expected %b actual %b", $time, want.last, rsp_run_last);
               errors++;
            end
            bytes_checked++;
            if (want.fend) frames_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t: timeout, %0d items still expected", $time, frame_q.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      cfg.dest_mac   = '0;
      cfg.src_mac    = '0;
      cfg.ether_type = ETHER_TYPE_RST;
      fcs_acc        = CRC_INIT;
      pay_cnt        = 0;
      open_frame     = 1'b0;

      // reset header: twelve zero bytes then 08 00
      dir_tab = '{
         '{8'h00, 1'b1, 64, 8'h00},
         '{8'hFF, 1'b0, 15, 8'h00},
         '{8'h01, 1'b0,  1, 8'h01},
         '{8'h02, 1'b0,  1, 8'h02},
         '{8'h04, 1'b0,  1, 8'h04},
         '{8'h08, 1'b0,  1, 8'h08},
         '{8'h10, 1'b0,  1, 8'h10},
         '{8'h20, 1'b0,  1, 8'h20},
         '{8'h40, 1'b0,  1, 8'h40},
         '{8'h80, 1'b0,  1, 8'h80},
         '{8'hAA, 1'b1, 41, 8'hAA},
         '{8'h55, 1'b1, 64, 8'h00},
         '{8'hA5, 1'b0, 15, 8'h00},
         '{8'h5A, 1'b1, 49, 8'h5A},
         '{8'hC3, 1'b0, 15, 8'h00}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 32;
      rx_idle_pct = 49;
      csr_write(CSR_SPARE, rand48());
      csr_we <= 1'b0;
      for (int i = 0; i < 15; i++) begin
         offer(dir_tab[i].pb, dir_tab[i].de);
         if (dir_tab[i].n_exp != 0 &&
             (run_n != dir_tab[i].n_exp || run_first != dir_tab[i].first_exp)) begin
            $display("%0t: row %0d expected %0d items from %02h, predicted %0d from %02h",
                     $time, i, dir_tab[i].n_exp, dir_tab[i].first_exp, run_n, run_first);
            errors++;
         end
      end
      drain();

      cfg_load({CSR_W{1'b1}}, '0, {rand48()} | 48'hFFFF);
      hold_req = 1'b1;
      random_frames(RAND_ITEMS);
      drain();

      tx_idle_pct = 49;
      rx_idle_pct = 32;
      cfg_load('0, {CSR_W{1'b1}}, rand48() & ~48'hFFFF);
      random_frames(RAND_ITEMS);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      cfg_load(rand48(), rand48(), rand48());
      offer(8'($urandom_range(255)), 1'b1);
      random_frames(RAND_ITEMS);
      drain();

      $display("Covered %0d items, %0d frames and %0d frame bytes; %0d mismatches.",
               items_sent, frames_seen, bytes_checked, errors);
      $display("Headers at reset, extreme and random addresses; short, padded and long frames.");
      if (errors == 0 && frame_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
